/* rtl/banked_interrupt_controller_top_defines.svh */
// Assertion macros used by the controller checker.
`ifndef BANKED_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH
`define BANKED_INTERRUPT_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define BIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bic assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define BIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bic assertion failed");

`endif

/* rtl/bic_pkg.sv */
// Types, codes and helpers of the banked interrupt controller.
`default_nettype none
package bic_pkg;

    localparam int LINES_PER_BANK = 32;
    localparam int BIT_W          = 5;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_LEVEL = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        GRP_TYPE  = 3'd0,
        GRP_POL   = 3'd1,
        GRP_CLASS = 3'd2,
        GRP_MASK  = 3'd3,
        GRP_CLEAR = 3'd4,
        GRP_IRQ   = 3'd5,
        GRP_FIQ   = 3'd6
    } t_group;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    // Index of the lowest set bit; zero for an empty word.
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [LINES_PER_BANK-1:0] v);
        logic [LINES_PER_BANK-1:0] iso;
        logic [BIT_W-1:0]          idx;
        iso = v & (~v + LINES_PER_BANK'(1));
        idx = '0;
        for (int i = 0; i < LINES_PER_BANK; i++) begin
            if (iso[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

/* rtl/bic_if.sv */
// Valid/ready channel interfaces for controller requests and responses.
`default_nettype none
interface bic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [2:0]  reg_group;
    logic [2:0]  bank;
    logic [31:0] write_data;
    logic [7:0]  line;
    logic        level;

    modport source (output valid, action, reg_group, bank, write_data, line, level,
                    input ready);
    modport sink   (input valid, action, reg_group, bank, write_data, line, level,
                    output ready);
endinterface

interface bic_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [7:0]  vector;
    logic        vector_found;
    logic        vector_is_fiq;

    modport source (output valid, read_data, vector, vector_found, vector_is_fiq,
                    input ready);
    modport sink   (input valid, read_data, vector, vector_found, vector_is_fiq,
                    output ready);
endinterface
`default_nettype wire

/* rtl/banked_interrupt_controller_top.sv */
// Banked interrupt controller: request channel in, one response per request out.
// Requests arrive on i_in (valid/ready); each transfer is a bus write, a bus
// read, a line level change or a vector query. Every request yields exactly one
// transfer on o_out, in request order.
// One request is worked at a time: i_in.ready is high only in idle. A write,
// read or level change is done in the execute state; a query walks the banks
// one per cycle through a single status/priority unit and stops at the first bank
// with a set line, or at the last bank. The finish state then moves the result
// into the output register, and the next request can be accepted in the cycle
// after that load.
// The output register frees the core: if it is full and o_out.ready is low, the
// finished result is held in the core until the register empties, and i_in stays
// blocked meanwhile. Nothing is dropped.
// Synchronous active-low reset restores all lines to edge trigger, high active,
// IRQ class, masked, with no pending edges and all levels low; the output
// register empties and i_in.ready stays low while reset is asserted.
`default_nettype none
module banked_interrupt_controller_top
    import bic_pkg::*;
#(
    parameter int BANKS = 7
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bic_in_if.sink    i_in,
    bic_out_if.source o_out
);

    localparam int           BANK_IW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam logic [3:0]   BANKS_L = 4'(BANKS);
    localparam logic [BANK_IW-1:0] LAST_BANK = BANK_IW'(BANKS - 1);

    t_state r_state, n_state;

    logic [LINES_PER_BANK-1:0] r_trig [BANKS];
    logic [LINES_PER_BANK-1:0] r_pol  [BANKS];
    logic [LINES_PER_BANK-1:0] r_cls  [BANKS];
    logic [LINES_PER_BANK-1:0] r_mask [BANKS];
    logic [LINES_PER_BANK-1:0] r_pend [BANKS];
    logic [LINES_PER_BANK-1:0] r_lvl  [BANKS];

    t_action             r_act;
    t_group              r_grp;
    logic [BANK_IW-1:0]  r_bank, n_bank;
    logic                r_ok;
    logic [31:0]         r_wdata;
    logic [BIT_W-1:0]    r_bit;
    logic                r_level;

    logic [31:0]         r_res_rdata, n_res_rdata;
    logic [7:0]          r_res_vec, n_res_vec;
    logic                r_res_found, n_res_found;
    logic                r_res_fiq, n_res_fiq;

    logic                r_ovalid;
    logic [31:0]         r_orddata;
    logic [7:0]          r_ovec;
    logic                r_ofound;
    logic                r_ofiq;

    logic                in_fire;
    logic                out_load;
    logic                row_we;
    logic [LINES_PER_BANK-1:0] n_trig_row, n_pol_row, n_cls_row, n_mask_row;
    logic [LINES_PER_BANK-1:0] n_pend_row, n_lvl_row;
    logic [LINES_PER_BANK-1:0] cur_trig, cur_pol, cur_cls, cur_mask, cur_pend, cur_lvl;
    logic [LINES_PER_BANK-1:0] raw, st_irq, st_fiq;
    logic [LINES_PER_BANK-1:0] bit_mask;
    logic [BIT_W-1:0]    irq_idx, fiq_idx;
    logic [2:0]          line_bank;

    assign line_bank = i_in.line[7:5];
    assign in_fire   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && i_rst_n;

    // Shared per-bank status unit.
    assign cur_trig = r_trig[r_bank];
    assign cur_pol  = r_pol[r_bank];
    assign cur_cls  = r_cls[r_bank];
    assign cur_mask = r_mask[r_bank];
    assign cur_pend = r_pend[r_bank];
    assign cur_lvl  = r_lvl[r_bank];
    assign raw      = ((cur_lvl ^ cur_pol) & ~cur_trig) | (cur_pend & cur_trig);
    assign st_irq   = raw & cur_mask & cur_cls;
    assign st_fiq   = raw & cur_mask & ~cur_cls;
    assign irq_idx  = lowest_bit(st_irq);
    assign fiq_idx  = lowest_bit(st_fiq);
    assign bit_mask = LINES_PER_BANK'(1) << r_bit;

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_res_rdata = r_res_rdata;
        n_res_vec   = r_res_vec;
        n_res_found = r_res_found;
        n_res_fiq   = r_res_fiq;
        row_we      = 1'b0;
        n_trig_row  = cur_trig;
        n_pol_row   = cur_pol;
        n_cls_row   = cur_cls;
        n_mask_row  = cur_mask;
        n_pend_row  = cur_pend;
        n_lvl_row   = cur_lvl;
        out_load    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_res_rdata = '0;
                    n_res_vec   = '0;
                    n_res_found = 1'b0;
                    n_res_fiq   = 1'b0;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FIN;
                case (r_act)
                    ACT_WRITE: begin
                        row_we = r_ok;
                        case (r_grp)
                            GRP_TYPE:  n_trig_row = r_wdata;
                            GRP_POL:   n_pol_row  = r_wdata;
                            GRP_CLASS: n_cls_row  = r_wdata;
                            GRP_MASK:  n_mask_row = r_wdata;
                            GRP_CLEAR: n_pend_row = cur_pend & ~r_wdata;
                            default:   n_pend_row = cur_pend;
                        endcase
                    end
                    ACT_READ: begin
                        if (r_ok) begin
                            case (r_grp)
                                GRP_TYPE:  n_res_rdata = cur_trig;
                                GRP_POL:   n_res_rdata = cur_pol;
                                GRP_CLASS: n_res_rdata = cur_cls;
                                GRP_MASK:  n_res_rdata = cur_mask;
                                GRP_IRQ:   n_res_rdata = st_irq;
                                GRP_FIQ:   n_res_rdata = st_fiq;
                                default:   n_res_rdata = '0;
                            endcase
                        end
                    end
                    ACT_LEVEL: begin
                        row_we = r_ok;
                        if ((((cur_lvl & bit_mask) != '0) != r_level) &&
                            (r_level == ((cur_pol & bit_mask) == '0)) &&
                            ((cur_trig & bit_mask) != '0)) begin
                            n_pend_row = cur_pend | bit_mask;
                        end
                        n_lvl_row = r_level ? (cur_lvl | bit_mask) : (cur_lvl & ~bit_mask);
                    end
                    ACT_QUERY: begin
                        if (st_irq != '0) begin
                            n_res_vec   = {3'(r_bank), irq_idx};
                            n_res_found = 1'b1;
                        end else if (st_fiq != '0) begin
                            n_res_vec   = {3'(r_bank), fiq_idx};
                            n_res_found = 1'b1;
                            n_res_fiq   = 1'b1;
                        end else if (r_bank != LAST_BANK) begin
                            n_bank  = r_bank + BANK_IW'(1);
                            n_state = ST_EXEC;
                        end
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANKS; b++) begin
                r_trig[b] <= '1;
                r_pol[b]  <= '0;
                r_cls[b]  <= '1;
                r_mask[b] <= '0;
                r_pend[b] <= '0;
                r_lvl[b]  <= '0;
            end
        end else if (row_we) begin
            r_trig[r_bank] <= n_trig_row;
            r_pol[r_bank]  <= n_pol_row;
            r_cls[r_bank]  <= n_cls_row;
            r_mask[r_bank] <= n_mask_row;
            r_pend[r_bank] <= n_pend_row;
            r_lvl[r_bank]  <= n_lvl_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act   <= t_action'(i_in.action);
            r_grp   <= t_group'(i_in.reg_group);
            r_wdata <= i_in.write_data;
            r_bit   <= i_in.line[BIT_W-1:0];
            r_level <= i_in.level;
            case (t_action'(i_in.action))
                ACT_LEVEL: begin
                    r_bank <= BANK_IW'(line_bank);
                    r_ok   <= ({1'b0, line_bank} < BANKS_L);
                end
                ACT_QUERY: begin
                    r_bank <= '0;
                    r_ok   <= 1'b1;
                end
                default: begin
                    r_bank <= BANK_IW'(i_in.bank);
                    r_ok   <= ({1'b0, i_in.bank} < BANKS_L);
                end
            endcase
        end else begin
            r_bank <= n_bank;
        end
        r_res_rdata <= n_res_rdata;
        r_res_vec   <= n_res_vec;
        r_res_found <= n_res_found;
        r_res_fiq   <= n_res_fiq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_orddata <= r_res_rdata;
            r_ovec    <= r_res_vec;
            r_ofound  <= r_res_found;
            r_ofiq    <= r_res_fiq;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.read_data     = r_orddata;
    assign o_out.vector        = r_ovec;
    assign o_out.vector_found  = r_ofound;
    assign o_out.vector_is_fiq = r_ofiq;

endmodule
`default_nettype wire

/* rtl/bic_checker.sv */
// Port-level checks of the banked interrupt controller, bound to the top level.
`default_nettype none
`include "banked_interrupt_controller_top_defines.svh"
module bic_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_read_data,
    input wire [7:0]  i_vector,
    input wire        i_vector_found,
    input wire        i_vector_is_fiq
);

    `BIC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `BIC_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)
    `BIC_ASSERT_NOW(a_vec_zero, i_out_valid && !i_vector_found, i_vector == 8'd0 && !i_vector_is_fiq)
    `BIC_ASSERT_NOW(a_query_no_data, i_out_valid && i_vector_found, i_read_data == 32'd0)

endmodule

bind banked_interrupt_controller_top bic_checker u_bic_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_read_data     (o_out.read_data),
    .i_vector        (o_out.vector),
    .i_vector_found  (o_out.vector_found),
    .i_vector_is_fiq (o_out.vector_is_fiq)
);
`default_nettype wire
